FILE: src/imu_serial_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef IMU_SERIAL_FRAME_DECODER_MACROS_SVH
`define IMU_SERIAL_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/imu_sfd_pkg.sv
// Types and constants of the serial frame decoder.
package imu_sfd_pkg;

	localparam int FRAME_LENGTH = 11;
	localparam int NUM_CELLS    = FRAME_LENGTH - 2;
	localparam int NUM_AXES     = 3;
	localparam int POS_W        = 4;
	localparam int SCALE_W      = 12;
	localparam int RAW_W        = 16;
	localparam int VAL_W        = 18;
	localparam int FRAC_W       = 10;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;

	localparam logic KIND_RATE  = 1'b0;
	localparam logic KIND_ANGLE = 1'b1;

	localparam logic REG_RATE_SCALE  = 1'b0;
	localparam logic REG_ANGLE_SCALE = 1'b1;

	typedef struct packed {
		logic                                kind;
		logic [SCALE_W-1:0]                  scale;
		logic [NUM_AXES-1:0][RAW_W-1:0]      axis;
	} frame_t;

endpackage

FILE: src/imu_sfd_byte_cell.sv
// One byte cell of the frame shift line.
module imu_sfd_byte_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] d,
	output logic [7:0] byte_q
);

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

endmodule

FILE: src/imu_sfd_axis_scale.sv
// One axis value: signed raw count times Q10 scale, floor-shifted, held as latest.
module imu_sfd_axis_scale
	import imu_sfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [RAW_W-1:0]        raw,
	input  logic [SCALE_W-1:0]      scale,
	output logic signed [VAL_W-1:0] value_q
);

	localparam int PROD_W = RAW_W + SCALE_W + 1;

	logic signed [PROD_W-1:0] prod;

	assign prod = PROD_W'($signed(raw) * $signed({1'b0, scale}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (load) begin
			// drop the fraction bits: an arithmetic shift that rounds down
			value_q <= prod[FRAC_W+VAL_W-1:FRAC_W];
		end
	end

endmodule

FILE: src/imu_serial_frame_decoder.sv
// Top level of the serial frame decoder: byte shift line, frame capture, scaling.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | in        | in_valid / in_stall | rx_byte
//  out     | out       | out_valid/out_stall | frame_kind, rate_xyz, angle_roll/pitch/yaw
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the bytes move through a line
// of nine byte cells. A result leaves after the last byte of a frame once the frame
// is captured into a register and the axis multipliers have registered their values.
// Reset clears the byte position, the pending flags and the latest values.
// in_stall rises only while a captured frame waits behind a stalled result.
module imu_serial_frame_decoder
	import imu_sfd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               rx_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     frame_kind,
	output logic signed [VAL_W-1:0]  rate_x,
	output logic signed [VAL_W-1:0]  rate_y,
	output logic signed [VAL_W-1:0]  rate_z,
	output logic signed [VAL_W-1:0]  angle_roll,
	output logic signed [VAL_W-1:0]  angle_pitch,
	output logic signed [VAL_W-1:0]  angle_yaw,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [SCALE_W-1:0]       cfg_data
);

`include "imu_serial_frame_decoder_macros.svh"

	logic [SCALE_W-1:0] rate_scale_q;
	logic [SCALE_W-1:0] angle_scale_q;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         cell_q [NUM_CELLS];
	frame_t             frame_s1;
	logic               valid_s1;
	logic               out_valid_q;
	logic               kind_q;
	logic               in_acc;
	logic               last_byte;
	logic               type_known;
	logic               frame_done;
	logic               advance;
	logic [7:0]         type_byte;
	frame_t             frame_d;
	logic signed [VAL_W-1:0] rate_val  [NUM_AXES];
	logic signed [VAL_W-1:0] angle_val [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q  <= SCALE_W'(1116);
			angle_scale_q <= SCALE_W'(804);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE_SCALE:  rate_scale_q  <= cfg_data;
				REG_ANGLE_SCALE: angle_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// byte shift line: cell k holds the byte accepted k+1 requests ago
	genvar k;
	generate
		for (k = 0; k < NUM_CELLS; k++) begin : g_cell
			imu_sfd_byte_cell u_cell (
				.clk    (clk),
				.shift  (in_acc),
				.d      ((k == 0) ? rx_byte : cell_q[(k == 0) ? 0 : k-1]),
				.byte_q (cell_q[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (pos_q == '0) begin
				pos_q <= (rx_byte == HDR_BYTE) ? POS_W'(1) : '0;
			end else if (last_byte) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	assign last_byte  = (pos_q == POS_W'(FRAME_LENGTH - 1));
	assign type_byte  = cell_q[FRAME_LENGTH-3];
	assign type_known = (type_byte == TYPE_RATE) || (type_byte == TYPE_ANGLE);
	assign frame_done = in_acc && last_byte && type_known;

	always_comb begin
		frame_d.kind  = (type_byte == TYPE_ANGLE) ? KIND_ANGLE : KIND_RATE;
		frame_d.scale = (type_byte == TYPE_ANGLE) ? angle_scale_q : rate_scale_q;
		for (int i = 0; i < NUM_AXES; i++) begin
			// frame byte 2+2i is the low half, 3+2i the high half
			frame_d.axis[i] = {cell_q[FRAME_LENGTH-5-2*i], cell_q[FRAME_LENGTH-4-2*i]};
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			frame_s1 <= frame_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_RATE;
		end else begin
			if (frame_done) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				kind_q      <= frame_s1.kind;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	generate
		for (k = 0; k < NUM_AXES; k++) begin : g_axis
			imu_sfd_axis_scale u_rate (
				.clk     (clk),
				.arst_n  (arst_n),
				.load    (advance && (frame_s1.kind == KIND_RATE)),
				.raw     (frame_s1.axis[k]),
				.scale   (frame_s1.scale),
				.value_q (rate_val[k])
			);
			imu_sfd_axis_scale u_angle (
				.clk     (clk),
				.arst_n  (arst_n),
				.load    (advance && (frame_s1.kind == KIND_ANGLE)),
				.raw     (frame_s1.axis[k]),
				.scale   (frame_s1.scale),
				.value_q (angle_val[k])
			);
		end
	endgenerate

	assign out_valid   = out_valid_q;
	assign frame_kind  = kind_q;
	assign rate_x      = rate_val[0];
	assign rate_y      = rate_val[1];
	assign rate_z      = rate_val[2];
	assign angle_roll  = angle_val[0];
	assign angle_pitch = angle_val[1];
	assign angle_yaw   = angle_val[2];

	`IMU_ASSERT_NOW(a_pos_range, clk, arst_n, 1'b1, pos_q < POS_W'(FRAME_LENGTH), "byte position out of range")
	`IMU_ASSERT_NEXT(a_hunt_drop, clk, arst_n, in_acc && (pos_q == '0) && (rx_byte != HDR_BYTE), pos_q == '0, "non-header byte left hunt")
	`IMU_ASSERT_NEXT(a_frame_capture, clk, arst_n, frame_done, valid_s1, "known frame not captured")
	`IMU_ASSERT_NEXT(a_result_issue, clk, arst_n, advance, out_valid_q, "captured frame produced no result")

endmodule
